// ----- rtl/hybrid_branch_direction_predictor_assert.svh -----
`ifndef HYBRID_BRANCH_DIRECTION_PREDICTOR_ASSERT_SVH
`define HYBRID_BRANCH_DIRECTION_PREDICTOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HBDP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hbdp assertion failed");

// Next-cycle implication, checked out of reset.
`define HBDP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hbdp assertion failed");

`endif

// ----- rtl/hbdp_pkg.sv -----
package hbdp_pkg;

	typedef struct packed {
		logic [2:0] gag;
		logic [1:0] c_lg;
		logic [1:0] c_tlg;
		logic [1:0] c_tgg;
		logic [1:0] c_tgl;
	} gtab_t;

	typedef struct packed {
		logic [1:0] bim;
		logic [1:0] lpt;
		gtab_t      gt;
		logic [2:0] gsh;
	} ctrs_t;

	typedef struct packed {
		logic       back;
		logic [7:0] preds;
		logic [7:0] miss;
	} result_t;

	localparam int unsigned OUTQ_DEPTH = 4;
	localparam int unsigned OUTQ_AW    = 2;

endpackage

// ----- rtl/hybrid_branch_direction_predictor.sv -----
// A result passes through stage 1 and stage 2 and is then written into the output queue, from which it is offered.
// Throughput: one branch per cycle while in_ready is high; table reads at acceptance,
// the dependent pattern-table read from stage 1, and all write-backs from stage 2.
// Reset: the global history clears at once; all tables are then zeroed by a
// clearing pass over every entry, during which in_ready stays low.
module hybrid_branch_direction_predictor #(
	parameter int unsigned HISTORY_BITS     = 9,
	parameter int unsigned LOCAL_TABLE_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] branch_address,
	input  logic [63:0] target_address,
	input  logic        taken,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        backward,
	output logic [7:0]  predictions,
	output logic [7:0]  mispredicts
);

	localparam int unsigned H  = HISTORY_BITS;
	localparam int unsigned L  = LOCAL_TABLE_BITS;
	localparam int unsigned CW = (H > L) ? H : L;
	localparam int unsigned GW = $bits(hbdp_pkg::gtab_t);

	logic acc;
	logic clearing_q;
	logic [CW-1:0] clr_q;
	logic [H-1:0] ghist_q;

	// Stage 1
	logic v_s1, t_s1, back_s1;
	logic [H-1:0] bidx_s1, gh_s1, gsidx_s1;
	logic [L-1:0] lidx_s1;

	// Stage 2
	logic v_s2, t_s2, back_s2;
	logic [H-1:0] bidx_s2, gh_s2, gsidx_s2, lhist_s2;
	logic [L-1:0] lidx_s2;
	logic [1:0] bim_s2;
	logic [2:0] gsh_s2;
	hbdp_pkg::gtab_t gt_s2;

	// Writes made at the previous edge
	logic wv_q;
	logic [H-1:0] w_bidx_q, w_gh_q, w_gsidx_q, w_lh_q, w_lhn_q;
	logic [L-1:0] w_lidx_q;
	hbdp_pkg::ctrs_t w_nc_q;

	// RAM read data
	logic [1:0] bim_rd, lpt_rd;
	logic [2:0] gsh_rd;
	logic [H-1:0] lht_rd;
	logic [GW-1:0] gt_rd;

	// Forwarded values
	logic [1:0] bim_f, lpt_f;
	logic [2:0] gsh_f;
	logic [H-1:0] lhist_f, lhn_s2;
	hbdp_pkg::gtab_t gt_f;

	hbdp_pkg::ctrs_t cur_s2, nc_s2;
	hbdp_pkg::result_t res_s2;
	logic [hbdp_pkg::OUTQ_AW:0] q_count;
	logic [hbdp_pkg::OUTQ_AW+1:0] pending;

	// Write port shared by the clearing pass and stage 2.
	logic we;
	logic [H-1:0] wa_bidx, wa_gh, wa_gsidx, wa_lh;
	logic [L-1:0] wa_lidx;
	hbdp_pkg::ctrs_t wd;
	logic [H-1:0] wd_lhn;

	// Results in flight are counted against the queue so it never overflows.
	assign pending = {1'b0, q_count} + {{(hbdp_pkg::OUTQ_AW + 1){1'b0}}, v_s1}
		+ {{(hbdp_pkg::OUTQ_AW + 1){1'b0}}, v_s2};
	assign in_ready = !clearing_q && (pending < (hbdp_pkg::OUTQ_AW + 2)'(hbdp_pkg::OUTQ_DEPTH));
	assign acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
			ghist_q    <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			wv_q       <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == '1) clearing_q <= 1'b0;
			end
			if (acc) ghist_q <= {ghist_q[H-2:0], taken};
			v_s1 <= acc;
			v_s2 <= v_s1;
			wv_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		bidx_s1  <= branch_address[H-1:0];
		lidx_s1  <= branch_address[L-1:0];
		gh_s1    <= ghist_q;
		gsidx_s1 <= branch_address[H-1:0] ^ ghist_q;
		t_s1     <= taken;
		back_s1  <= !(target_address > branch_address);

		bidx_s2  <= bidx_s1;
		lidx_s2  <= lidx_s1;
		gh_s2    <= gh_s1;
		gsidx_s2 <= gsidx_s1;
		t_s2     <= t_s1;
		back_s2  <= back_s1;
		lhist_s2 <= lhist_f;
		bim_s2   <= bim_f;
		gsh_s2   <= gsh_f;
		gt_s2    <= gt_f;

		w_bidx_q  <= bidx_s2;
		w_lidx_q  <= lidx_s2;
		w_gh_q    <= gh_s2;
		w_gsidx_q <= gsidx_s2;
		w_lh_q    <= lhist_s2;
		w_lhn_q   <= lhn_s2;
		w_nc_q    <= nc_s2;
	end

	// Stage 1 misses the write of the previous edge and the one stage 2 makes now.
	always_comb begin
		if (v_s2 && bidx_s2 == bidx_s1) bim_f = nc_s2.bim;
		else if (wv_q && w_bidx_q == bidx_s1) bim_f = w_nc_q.bim;
		else bim_f = bim_rd;

		if (v_s2 && lidx_s2 == lidx_s1) lhist_f = lhn_s2;
		else if (wv_q && w_lidx_q == lidx_s1) lhist_f = w_lhn_q;
		else lhist_f = lht_rd;

		if (v_s2 && gh_s2 == gh_s1) gt_f = nc_s2.gt;
		else if (wv_q && w_gh_q == gh_s1) gt_f = w_nc_q.gt;
		else gt_f = hbdp_pkg::gtab_t'(gt_rd);

		if (v_s2 && gsidx_s2 == gsidx_s1) gsh_f = nc_s2.gsh;
		else if (wv_q && w_gsidx_q == gsidx_s1) gsh_f = w_nc_q.gsh;
		else gsh_f = gsh_rd;

		// The pattern table is read from stage 1 rather than at acceptance, so only the last write is missed.
		if (wv_q && w_lh_q == lhist_s2) lpt_f = w_nc_q.lpt;
		else lpt_f = lpt_rd;

		cur_s2.bim = bim_s2;
		cur_s2.lpt = lpt_f;
		cur_s2.gt  = gt_s2;
		cur_s2.gsh = gsh_s2;
		lhn_s2 = {lhist_s2[H-2:0], t_s2};
	end

	hbdp_pred u_pred (
		.cur   (cur_s2),
		.taken (t_s2),
		.back  (back_s2),
		.res   (res_s2),
		.upd   (nc_s2)
	);

	always_comb begin
		if (clearing_q) begin
			we       = 1'b1;
			wa_bidx  = clr_q[H-1:0];
			wa_lidx  = clr_q[L-1:0];
			wa_gh    = clr_q[H-1:0];
			wa_gsidx = clr_q[H-1:0];
			wa_lh    = clr_q[H-1:0];
			wd       = '0;
			wd_lhn   = '0;
		end else begin
			we       = v_s2;
			wa_bidx  = bidx_s2;
			wa_lidx  = lidx_s2;
			wa_gh    = gh_s2;
			wa_gsidx = gsidx_s2;
			wa_lh    = lhist_s2;
			wd       = nc_s2;
			wd_lhn   = lhn_s2;
		end
	end

	hbdp_ram #(.WIDTH(2), .DEPTH(2 ** H)) u_bim (
		.clk(clk), .we(we), .waddr(wa_bidx), .wdata(wd.bim),
		.raddr(branch_address[H-1:0]), .rdata(bim_rd)
	);

	hbdp_ram #(.WIDTH(H), .DEPTH(2 ** L)) u_lht (
		.clk(clk), .we(we), .waddr(wa_lidx), .wdata(wd_lhn),
		.raddr(branch_address[L-1:0]), .rdata(lht_rd)
	);

	hbdp_ram #(.WIDTH(2), .DEPTH(2 ** H)) u_lpt (
		.clk(clk), .we(we), .waddr(wa_lh), .wdata(wd.lpt),
		.raddr(lhist_f), .rdata(lpt_rd)
	);

	hbdp_ram #(.WIDTH(GW), .DEPTH(2 ** H)) u_gtab (
		.clk(clk), .we(we), .waddr(wa_gh), .wdata(wd.gt),
		.raddr(ghist_q), .rdata(gt_rd)
	);

	hbdp_ram #(.WIDTH(3), .DEPTH(2 ** H)) u_gsh (
		.clk(clk), .we(we), .waddr(wa_gsidx), .wdata(wd.gsh),
		.raddr(branch_address[H-1:0] ^ ghist_q), .rdata(gsh_rd)
	);

	hbdp_pkg::result_t q_dout;

	hbdp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s2),
		.din       (res_s2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dout      (q_dout),
		.count     (q_count)
	);

	assign backward    = q_dout.back;
	assign predictions = q_dout.preds;
	assign mispredicts = q_dout.miss;

`include "hybrid_branch_direction_predictor_assert.svh"

	`HBDP_ASSERT_NOW(a_no_accept_clearing, clearing_q, !acc)
	`HBDP_ASSERT_NOW(a_credit_bound, 1'b1, pending <= (hbdp_pkg::OUTQ_AW + 2)'(hbdp_pkg::OUTQ_DEPTH))
	`HBDP_ASSERT_NEXT(a_accept_enters_s1, acc, v_s1)
	`HBDP_ASSERT_NEXT(a_s1_reaches_s2, v_s1, v_s2)

endmodule

// ----- rtl/hbdp_ram.sv -----
module hbdp_ram #(
	parameter int unsigned WIDTH = 2,
	parameter int unsigned DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents when the same entry is written in that cycle.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

// ----- rtl/hbdp_pred.sv -----
module hbdp_pred (
	input  hbdp_pkg::ctrs_t   cur,
	input  logic              taken,
	input  logic              back,
	output hbdp_pkg::result_t res,
	output hbdp_pkg::ctrs_t   upd
);

	logic p_bim, p_sag, p_gag, p_gs, p_hyb, p_maj, p_tour;
	logic m_sag, m_gag, m_gs;
	logic [7:0] preds;

	function automatic logic [1:0] sat2(input logic [1:0] v, input logic up);
		logic [1:0] r;
		r = v;
		if (up && v != 2'd3) r = v + 2'd1;
		if (!up && v != 2'd0) r = v - 2'd1;
		return r;
	endfunction

	function automatic logic [2:0] sat3(input logic [2:0] v, input logic up);
		logic [2:0] r;
		r = v;
		if (up && v != 3'd7) r = v + 3'd1;
		if (!up && v != 3'd0) r = v - 3'd1;
		return r;
	endfunction

	// A chooser moves only when exactly one of its two predictors missed.
	function automatic logic [1:0] choose(input logic [1:0] c, input logic fm,
			input logic sm);
		logic [1:0] r;
		r = c;
		if (fm != sm) r = sat2(c, fm);
		return r;
	endfunction

	always_comb begin
		p_bim = cur.bim[1];
		p_sag = cur.lpt[1];
		p_gag = cur.gt.gag[2];
		p_gs  = cur.gsh[2];
		p_hyb = cur.gt.c_lg[1] ? p_gag : p_sag;
		p_maj = (p_sag & p_gag) | (p_sag & p_gs) | (p_gag & p_gs);
		if (cur.gt.c_tlg[1]) begin
			p_tour = cur.gt.c_tgg[1] ? p_gs : p_gag;
		end else begin
			p_tour = cur.gt.c_tgl[1] ? p_sag : p_gs;
		end
		preds = {p_tour, p_maj, p_hyb, p_gs, p_gag, p_sag, p_bim, back};
		res.back  = back;
		res.preds = preds;
		res.miss  = preds ^ {8{taken}};
		m_sag = p_sag ^ taken;
		m_gag = p_gag ^ taken;
		m_gs  = p_gs ^ taken;
		upd.bim      = sat2(cur.bim, taken);
		upd.lpt      = sat2(cur.lpt, taken);
		upd.gt.gag   = sat3(cur.gt.gag, taken);
		upd.gsh      = sat3(cur.gsh, taken);
		upd.gt.c_lg  = choose(cur.gt.c_lg, m_sag, m_gag);
		upd.gt.c_tlg = choose(cur.gt.c_tlg, m_sag, m_gag);
		upd.gt.c_tgg = choose(cur.gt.c_tgg, m_gag, m_gs);
		upd.gt.c_tgl = choose(cur.gt.c_tgl, m_gs, m_sag);
	end

endmodule

// ----- rtl/hbdp_outq.sv -----
module hbdp_outq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  hbdp_pkg::result_t              din,
	output logic                           out_valid,
	input  logic                           out_ready,
	output hbdp_pkg::result_t              dout,
	output logic [hbdp_pkg::OUTQ_AW:0]     count
);

	hbdp_pkg::result_t mem_q [hbdp_pkg::OUTQ_DEPTH];
	logic [hbdp_pkg::OUTQ_AW-1:0] wp_q, rp_q;
	logic [hbdp_pkg::OUTQ_AW:0]   cnt_q;
	logic pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign dout      = mem_q[rp_q];
	assign count     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

endmodule
